FILE: rtl/assert_macros.svh
// Assertion macros shared by the pulse channel RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge outside reset.
`define PCTS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Implication checked on the following clock edge.
`define PCTS_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

FILE: rtl/pcts_pkg.sv
// Types, codes and sweep target helpers for the pulse channel core.
package pcts_pkg;

    localparam int OP_W     = 2;
    localparam int REG_W    = 2;
    localparam int DATA_W   = 8;
    localparam int PERIOD_W = 11;
    localparam int STEP_W   = 3;
    localparam int LEN_W    = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_TIMER = 2'd1;
    localparam logic [OP_W-1:0] OP_SWEEP = 2'd2;

    localparam logic [REG_W-1:0] REG_DUTY    = 2'd0;
    localparam logic [REG_W-1:0] REG_SWEEP   = 2'd1;
    localparam logic [REG_W-1:0] REG_TIMER_L = 2'd2;
    localparam logic [REG_W-1:0] REG_TIMER_H = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_TWO = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_TABLE  = 1'd1;

    localparam logic [CFG_DATA_W-1:0] DUTY_TABLE_RESET = 32'hF91E_0602;
    localparam logic [PERIOD_W-1:0]   MIN_PERIOD       = 11'd8;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [REG_W-1:0]  reg_index;
        logic [DATA_W-1:0] write_data;
    } t_in_beat;

    typedef struct packed {
        logic                pulse_gate;
        logic                sweep_muted;
        logic [STEP_W-1:0]   duty_position;
        logic [PERIOD_W-1:0] period_now;
        logic                length_load_valid;
        logic [LEN_W-1:0]    length_load_index;
        logic                envelope_restart;
    } t_out_beat;

    // Sweep target, one bit wider than the period; negative clamps to zero.
    function automatic logic [PERIOD_W:0] pcts_target(
        input logic [PERIOD_W-1:0] period,
        input logic [2:0]          shift,
        input logic                subtract,
        input logic                chan_two
    );
        logic [PERIOD_W-1:0] change;
        logic [PERIOD_W:0]   sub;
        logic [PERIOD_W:0]   result;
        change = period >> shift;
        sub    = {1'b0, change} + {{PERIOD_W{1'b0}}, ~chan_two};
        if (subtract) begin
            if (sub > {1'b0, period}) begin
                result = '0;
            end else begin
                result = {1'b0, period} - sub;
            end
        end else begin
            result = {1'b0, period} + {1'b0, change};
        end
        return result;
    endfunction

    function automatic logic pcts_muted(
        input logic [PERIOD_W-1:0] period,
        input logic [PERIOD_W:0]   target
    );
        return (period < MIN_PERIOD) || target[PERIOD_W];
    endfunction

endpackage

FILE: rtl/pcts_if.sv
// Channel interfaces of the pulse channel core: item in, result out, config write.
interface pcts_in_if import pcts_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [REG_W-1:0]  reg_index;
    logic [DATA_W-1:0] write_data;

    modport source (output valid, output operation, output reg_index, output write_data,
                    input ready);
    modport sink   (input valid, input operation, input reg_index, input write_data,
                    output ready);
endinterface

interface pcts_out_if import pcts_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                pulse_gate;
    logic                sweep_muted;
    logic [STEP_W-1:0]   duty_position;
    logic [PERIOD_W-1:0] period_now;
    logic                length_load_valid;
    logic [LEN_W-1:0]    length_load_index;
    logic                envelope_restart;

    modport source (output valid, output pulse_gate, output sweep_muted,
                    output duty_position, output period_now, output length_load_valid,
                    output length_load_index, output envelope_restart, input ready);
    modport sink   (input valid, input pulse_gate, input sweep_muted,
                    input duty_position, input period_now, input length_load_valid,
                    input length_load_index, input envelope_restart, output ready);
endinterface

interface pcts_cfg_if import pcts_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/pulse_channel_timer_duty_sweep.sv
// Pulse channel core: period timer, duty sequencer and sweep unit.
//
// Channels: i_in takes one beat per item (register write, timer tick or
// sweep tick); o_out gives one result beat per item; i_cfg writes the
// channel_two flag (index 0) and the duty pattern table (index 1), and is
// always ready. Config is to be written by the user only while no item is
// in flight; the block does not enforce this. An accepted item goes into
// the input register, then its result into the result register. Throughput:
// one item per cycle while o_out.ready is high, set by the combinational
// next-state logic between the two registers (one shift, two 12-bit adds
// and one compare per target evaluation). The input register takes a beat
// while a result waits; i_in.ready drops only when both registers hold beats
// and o_out.ready is low. Reset (i_rst_n low at an edge) clears all channel
// state to zero, restores the default duty table and empties both registers.
module pulse_channel_timer_duty_sweep import pcts_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    pcts_in_if.sink    i_in,
    pcts_out_if.source o_out,
    pcts_cfg_if.sink   i_cfg
);

`include "assert_macros.svh"

    logic                  r_channel_two;
    logic [CFG_DATA_W-1:0] r_duty_table;

    logic [1:0]          r_duty_sel,   n_duty_sel;
    logic                r_sweep_on,   n_sweep_on;
    logic [2:0]          r_reload_per, n_reload_per;
    logic                r_subtract,   n_subtract;
    logic [2:0]          r_shift,      n_shift;
    logic                r_pending,    n_pending;
    logic [2:0]          r_sweep_cd,   n_sweep_cd;
    logic [PERIOD_W-1:0] r_period,     n_period;
    logic [PERIOD_W-1:0] r_timer_cd,   n_timer_cd;
    logic [STEP_W-1:0]   r_step,       n_step;

    logic      r_in_valid;
    t_in_beat  r_in;
    logic      r_out_valid;
    t_out_beat r_out;
    t_out_beat n_out;

    logic move;

    assign move       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || move;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid             = r_out_valid;
    assign o_out.pulse_gate        = r_out.pulse_gate;
    assign o_out.sweep_muted       = r_out.sweep_muted;
    assign o_out.duty_position     = r_out.duty_position;
    assign o_out.period_now        = r_out.period_now;
    assign o_out.length_load_valid = r_out.length_load_valid;
    assign o_out.length_load_index = r_out.length_load_index;
    assign o_out.envelope_restart  = r_out.envelope_restart;

    always_comb begin
        logic [PERIOD_W:0] old_tgt;
        logic              old_muted;
        logic [PERIOD_W:0] new_tgt;
        logic              new_muted;

        n_duty_sel   = r_duty_sel;
        n_sweep_on   = r_sweep_on;
        n_reload_per = r_reload_per;
        n_subtract   = r_subtract;
        n_shift      = r_shift;
        n_pending    = r_pending;
        n_sweep_cd   = r_sweep_cd;
        n_period     = r_period;
        n_timer_cd   = r_timer_cd;
        n_step       = r_step;
        n_out.length_load_valid = 1'b0;
        n_out.length_load_index = '0;
        n_out.envelope_restart  = 1'b0;

        old_tgt   = pcts_target(r_period, r_shift, r_subtract, r_channel_two);
        old_muted = pcts_muted(r_period, old_tgt);

        case (r_in.operation)
            OP_WRITE: begin
                case (r_in.reg_index)
                    REG_DUTY: begin
                        n_duty_sel = r_in.write_data[7:6];
                    end
                    REG_SWEEP: begin
                        n_sweep_on   = r_in.write_data[7];
                        n_reload_per = r_in.write_data[6:4];
                        n_subtract   = r_in.write_data[3];
                        n_shift      = r_in.write_data[2:0];
                        n_pending    = 1'b1;
                    end
                    REG_TIMER_L: begin
                        n_period[7:0] = r_in.write_data;
                    end
                    REG_TIMER_H: begin
                        n_period[10:8] = r_in.write_data[2:0];
                        n_step         = '0;
                        n_out.length_load_valid = 1'b1;
                        n_out.length_load_index = r_in.write_data[7:3];
                        n_out.envelope_restart  = 1'b1;
                    end
                    default: begin
                        n_duty_sel = r_duty_sel;
                    end
                endcase
            end
            OP_TIMER: begin
                if (r_timer_cd == '0) begin
                    n_timer_cd = r_period;
                    n_step     = r_step + 3'd1;
                end else begin
                    n_timer_cd = r_timer_cd - 11'd1;
                end
            end
            OP_SWEEP: begin
                if (r_sweep_cd == '0 && r_sweep_on && r_shift != '0 && !old_muted) begin
                    n_period = old_tgt[PERIOD_W-1:0];
                end
                if (r_sweep_cd == '0 || r_pending) begin
                    n_sweep_cd = r_reload_per;
                    n_pending  = 1'b0;
                end else begin
                    n_sweep_cd = r_sweep_cd - 3'd1;
                end
            end
            default: begin
                n_step = r_step;
            end
        endcase

        new_tgt   = pcts_target(n_period, n_shift, n_subtract, r_channel_two);
        new_muted = pcts_muted(n_period, new_tgt);

        n_out.sweep_muted   = new_muted;
        n_out.pulse_gate    = r_duty_table[{n_duty_sel, n_step}] && !new_muted;
        n_out.duty_position = n_step;
        n_out.period_now    = n_period;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_two <= 1'b0;
            r_duty_table  <= DUTY_TABLE_RESET;
            r_duty_sel    <= '0;
            r_sweep_on    <= 1'b0;
            r_reload_per  <= '0;
            r_subtract    <= 1'b0;
            r_shift       <= '0;
            r_pending     <= 1'b0;
            r_sweep_cd    <= '0;
            r_period      <= '0;
            r_timer_cd    <= '0;
            r_step        <= '0;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_CHANNEL_TWO: r_channel_two <= i_cfg.data[0];
                    CFG_DUTY_TABLE:  r_duty_table  <= i_cfg.data;
                    default:         r_duty_table  <= r_duty_table;
                endcase
            end
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (move) begin
                r_duty_sel   <= n_duty_sel;
                r_sweep_on   <= n_sweep_on;
                r_reload_per <= n_reload_per;
                r_subtract   <= n_subtract;
                r_shift      <= n_shift;
                r_pending    <= n_pending;
                r_sweep_cd   <= n_sweep_cd;
                r_period     <= n_period;
                r_timer_cd   <= n_timer_cd;
                r_step       <= n_step;
                r_out_valid  <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in.operation  <= i_in.operation;
            r_in.reg_index  <= i_in.reg_index;
            r_in.write_data <= i_in.write_data;
        end
        if (move) begin
            r_out <= n_out;
        end
    end

    `PCTS_ASSERT_NEXT(a_period_hold, !move, $stable(r_period), "period changed without an item")
    `PCTS_ASSERT_NEXT(a_step_restart,
        move && r_in.operation == OP_WRITE && r_in.reg_index == REG_TIMER_H,
        r_step == '0, "sequencer not restarted by period high write")
    `PCTS_ASSERT_NEXT(a_timer_count,
        move && r_in.operation == OP_TIMER && r_timer_cd != '0,
        r_timer_cd == $past(r_timer_cd) - 11'd1, "timer countdown skipped")
    `PCTS_ASSERT(a_out_from_move, $rose(r_out_valid) |-> $past(move),
        "result beat without a processed item")

endmodule

FILE: bench/tb_pulse_channel_timer_duty_sweep.sv
// Testbench for the pulse channel core: random and directed items checked against a local model.
`timescale 1ns / 1ps

module tb_pulse_channel_timer_duty_sweep;
    import pcts_pkg::*;

    localparam logic [OP_W-1:0] OP_NONE = 2'd3;
    localparam int RESET_CYCLES = 11;
    localparam int PHASE_ITEMS  = 140;
    localparam int IDLE_LIMIT   = 2000;
    localparam int SQUEEZE_LEN  = 90;
    localparam int MAX_REPORTS  = 100;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pcts_in_if  in_bus ();
    pcts_out_if out_bus ();
    pcts_cfg_if cfg_bus ();

    pulse_channel_timer_duty_sweep i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // channel model state
    bit                ch_two;
    bit [31:0]         duty_pat;
    bit [1:0]          duty_sel;
    bit                swp_en;
    bit [2:0]          swp_div;
    bit                swp_neg;
    bit [2:0]          swp_shift;
    bit                swp_reload;
    bit [2:0]          swp_cnt;
    bit [PERIOD_W-1:0] tmr_period;
    bit [PERIOD_W-1:0] tmr_cnt;
    bit [STEP_W-1:0]   seq_step;

    t_in_beat  pend_q [$];
    t_out_beat exp_q [$];
    int  items_queued = 0;
    int  items_taken  = 0;
    int  errors       = 0;
    int  idle_cycles  = 0;
    bit  in_took      = 1'b0;
    bit  out_took     = 1'b0;
    int  snd_gap      = 0;
    bit  snd_quiet    = 1'b0;
    int  rcv_stall    = 0;
    bit  rcv_quiet    = 1'b0;
    int  hold_cnt     = 0;
    int  squeezes     = 0;

    task automatic reset_channel();
        ch_two     = 1'b0;
        duty_pat   = DUTY_TABLE_RESET;
        duty_sel   = '0;
        swp_en     = 1'b0;
        swp_div    = '0;
        swp_neg    = 1'b0;
        swp_shift  = '0;
        swp_reload = 1'b0;
        swp_cnt    = '0;
        tmr_period = '0;
        tmr_cnt    = '0;
        seq_step   = '0;
    endtask

    // sweep target, 12 bits; negative clamps to zero
    function automatic bit [PERIOD_W:0] sweep_goal();
        bit [PERIOD_W-1:0] delta;
        bit [PERIOD_W:0]   dec;
        delta = tmr_period >> swp_shift;
        dec   = {1'b0, delta} + (ch_two ? 12'd0 : 12'd1);
        if (swp_neg) begin
            return (dec > {1'b0, tmr_period}) ? '0 : {1'b0, tmr_period} - dec;
        end
        return {1'b0, tmr_period} + {1'b0, delta};
    endfunction

    function automatic bit channel_muted();
        return (tmr_period < MIN_PERIOD) || (sweep_goal() > 12'h7FF);
    endfunction

    task automatic advance_channel(input t_in_beat b, output t_out_beat r);
        bit [PERIOD_W:0] goal;
        bit              mute;
        r = '0;
        case (b.operation)
            OP_WRITE: begin
                case (b.reg_index)
                    REG_DUTY: begin
                        duty_sel = b.write_data[7:6];
                    end
                    REG_SWEEP: begin
                        swp_en     = b.write_data[7];
                        swp_div    = b.write_data[6:4];
                        swp_neg    = b.write_data[3];
                        swp_shift  = b.write_data[2:0];
                        swp_reload = 1'b1;
                    end
                    REG_TIMER_L: begin
                        tmr_period[7:0] = b.write_data;
                    end
                    default: begin
                        tmr_period[10:8]    = b.write_data[2:0];
                        seq_step            = '0;
                        r.length_load_valid = 1'b1;
                        r.length_load_index = b.write_data[7:3];
                        r.envelope_restart  = 1'b1;
                    end
                endcase
            end
            OP_TIMER: begin
                if (tmr_cnt == 0) begin
                    tmr_cnt  = tmr_period;
                    seq_step = seq_step + 1'b1;
                end else begin
                    tmr_cnt = tmr_cnt - 1'b1;
                end
            end
            OP_SWEEP: begin
                goal = sweep_goal();
                if (swp_cnt == 0 && swp_en && swp_shift != 0 && !channel_muted()) begin
                    tmr_period = goal[PERIOD_W-1:0];
                end
                if (swp_cnt == 0 || swp_reload) begin
                    swp_cnt    = swp_div;
                    swp_reload = 1'b0;
                end else begin
                    swp_cnt = swp_cnt - 1'b1;
                end
            end
            default: ;
        endcase
        mute            = channel_muted();
        r.sweep_muted   = mute;
        r.pulse_gate    = duty_pat[{duty_sel, seq_step}] & ~mute;
        r.duty_position = seq_step;
        r.period_now    = tmr_period;
    endtask

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned seen);
        if (want != seen) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
                $display("%0t mismatch %s: expected %0d, actual %0d", $time, what, want, seen);
            end
        end
    endtask

    // acceptance, prediction, result check, watchdog
    always @(posedge i_clk) begin
        t_in_beat  got;
        t_out_beat want;
        t_out_beat seen;
        bit        moved;
        in_took  <= in_bus.valid && in_bus.ready;
        out_took <= out_bus.valid && out_bus.ready;
        moved = 1'b0;
        if (!i_rst_n) begin
            reset_channel();
        end else begin
            if (cfg_bus.valid && cfg_bus.ready) begin
                moved = 1'b1;
                case (cfg_bus.index)
                    CFG_CHANNEL_TWO: ch_two = cfg_bus.data[0];
                    CFG_DUTY_TABLE:  duty_pat = cfg_bus.data;
                    default: ;
                endcase
            end
            if (in_bus.valid && in_bus.ready) begin
                moved = 1'b1;
                got.operation  = in_bus.operation;
                got.reg_index  = in_bus.reg_index;
                got.write_data = in_bus.write_data;
                advance_channel(got, want);
                exp_q.push_back(want);
                items_taken++;
            end
            if (out_bus.valid && out_bus.ready) begin
                moved = 1'b1;
                seen.pulse_gate        = out_bus.pulse_gate;
                seen.sweep_muted       = out_bus.sweep_muted;
                seen.duty_position     = out_bus.duty_position;
                seen.period_now        = out_bus.period_now;
                seen.length_load_valid = out_bus.length_load_valid;
                seen.length_load_index = out_bus.length_load_index;
                seen.envelope_restart  = out_bus.envelope_restart;
                if (exp_q.size() == 0) begin
                    errors++;
                    $display("%0t unexpected result beat: expected none, actual %h", $time, seen);
                end else begin
                    want = exp_q.pop_front();
                    check_field("pulse_gate", want.pulse_gate, seen.pulse_gate);
                    check_field("sweep_muted", want.sweep_muted, seen.sweep_muted);
                    check_field("duty_position", want.duty_position, seen.duty_position);
                    check_field("period_now", want.period_now, seen.period_now);
                    check_field("length_load_valid", want.length_load_valid,
                                seen.length_load_valid);
                    check_field("length_load_index", want.length_load_index,
                                seen.length_load_index);
                    check_field("envelope_restart", want.envelope_restart,
                                seen.envelope_restart);
                end
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t watchdog: no beat for %0d cycles", $time, IDLE_LIMIT);
            $display("pulse_channel_timer_duty_sweep regression: fail");
            $finish;
        end
    end

    // sender
    always @(negedge i_clk) begin
        t_in_beat nxt;
        bit       offer;
        if (i_rst_n && !(in_bus.valid && !in_took)) begin
            offer = 1'b0;
            if (snd_gap != 0) begin
                snd_gap--;
            end else if (pend_q.size() != 0) begin
                nxt   = pend_q.pop_front();
                offer = 1'b1;
                in_bus.operation  <= nxt.operation;
                in_bus.reg_index  <= nxt.reg_index;
                in_bus.write_data <= nxt.write_data;
                if ($urandom_range(0, 39) == 0) snd_quiet = !snd_quiet;
                snd_gap = snd_quiet ? 0 : $urandom_range(0, 13);
            end
            in_bus.valid <= offer;
        end
    end

    // long receiver hold-off, twice, while the sender keeps going
    always @(negedge i_clk) begin
        if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if ((squeezes == 0 && items_taken >= 100) ||
                     (squeezes == 1 && items_taken >= 420)) begin
            hold_cnt <= SQUEEZE_LEN;
            squeezes <= squeezes + 1;
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (out_took) begin
            if ($urandom_range(0, 39) == 0) rcv_quiet = !rcv_quiet;
            rcv_stall = rcv_quiet ? 0 : $urandom_range(0, 13);
        end
        if (!i_rst_n || hold_cnt != 0) begin
            out_bus.ready <= 1'b0;
        end else if (rcv_stall != 0) begin
            rcv_stall--;
            out_bus.ready <= 1'b0;
        end else begin
            out_bus.ready <= 1'b1;
        end
    end

    function automatic t_in_beat beat(input logic [OP_W-1:0] op,
                                      input logic [REG_W-1:0] idx,
                                      input logic [DATA_W-1:0] data);
        t_in_beat b;
        b.operation  = op;
        b.reg_index  = idx;
        b.write_data = data;
        return b;
    endfunction

    // mostly ticks and period writes that keep the timer short enough to wrap
    function automatic t_in_beat random_beat();
        t_in_beat b;
        int       sel;
        sel = $urandom_range(0, 99);
        b.reg_index  = REG_W'($urandom_range(0, 3));
        b.write_data = DATA_W'($urandom_range(0, 255));
        if (sel < 3) begin
            b.operation = OP_NONE;
        end else if (sel < 50) begin
            b.operation = OP_TIMER;
        end else if (sel < 68) begin
            b.operation = OP_SWEEP;
        end else begin
            b.operation = OP_WRITE;
            if (b.reg_index == REG_TIMER_L && $urandom_range(0, 1) == 0) begin
                b.write_data = DATA_W'($urandom_range(0, 24));
            end else if (b.reg_index == REG_TIMER_H && $urandom_range(0, 9) < 7) begin
                b.write_data[2:0] = '0;
            end
        end
        return b;
    endfunction

    task automatic queue_item(input t_in_beat b);
        pend_q.push_back(b);
        items_queued++;
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do @(posedge i_clk); while (!cfg_bus.ready);
    endtask

    task automatic apply_config(input bit two, input logic [31:0] pattern);
        cfg_write(CFG_CHANNEL_TWO, {31'd0, two});
        cfg_write(CFG_DUTY_TABLE, pattern);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic drain();
        while (items_taken != items_queued || exp_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin
        bit          phase_two [5];
        logic [31:0] phase_pat [5];
        i_rst_n            = 1'b0;
        in_bus.valid       = 1'b0;
        in_bus.operation   = OP_WRITE;
        in_bus.reg_index   = REG_DUTY;
        in_bus.write_data  = '0;
        out_bus.ready      = 1'b0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.index      = CFG_CHANNEL_TWO;
        cfg_bus.data       = '0;
        phase_two = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
        phase_pat = '{$urandom(), 32'hFFFF_FFFF, 32'h0000_0000, $urandom(), DUTY_TABLE_RESET};

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        apply_config(1'b0, DUTY_TABLE_RESET);
        queue_item(beat(OP_NONE, REG_TIMER_H, 8'hFF));
        queue_item(beat(OP_WRITE, REG_DUTY, 8'h3F));
        queue_item(beat(OP_WRITE, REG_TIMER_L, 8'hFF));
        queue_item(beat(OP_WRITE, REG_TIMER_H, 8'hFF));
        queue_item(beat(OP_SWEEP, REG_DUTY, 8'h00));     // muted with sweep off
        queue_item(beat(OP_WRITE, REG_TIMER_H, 8'h00));
        queue_item(beat(OP_WRITE, REG_SWEEP, 8'hFF));
        queue_item(beat(OP_SWEEP, REG_DUTY, 8'h00));
        queue_item(beat(OP_WRITE, REG_TIMER_L, 8'h03));  // period below 8
        repeat (4) queue_item(beat(OP_TIMER, REG_DUTY, 8'h00));
        queue_item(beat(OP_WRITE, REG_DUTY, 8'h40));
        queue_item(beat(OP_TIMER, REG_DUTY, 8'h00));
        queue_item(beat(OP_WRITE, REG_DUTY, 8'h80));
        queue_item(beat(OP_WRITE, REG_DUTY, 8'hC0));
        queue_item(beat(OP_WRITE, REG_TIMER_L, 8'h00));
        queue_item(beat(OP_WRITE, REG_SWEEP, 8'h89));    // negate, target clamps
        queue_item(beat(OP_SWEEP, REG_DUTY, 8'h00));
        queue_item(beat(OP_WRITE, REG_TIMER_H, 8'h04));
        queue_item(beat(OP_WRITE, REG_SWEEP, 8'h81));
        repeat (3) queue_item(beat(OP_SWEEP, REG_DUTY, 8'h00));
        queue_item(beat(OP_WRITE, REG_SWEEP, 8'h80));    // shift zero
        queue_item(beat(OP_SWEEP, REG_DUTY, 8'h00));
        drain();

        for (int p = 0; p < 5; p++) begin
            apply_config(phase_two[p], phase_pat[p]);
            for (int k = 0; k < PHASE_ITEMS; k++) queue_item(random_beat());
            drain();
        end

        repeat (4) @(posedge i_clk);
        if (errors == 0 && exp_q.size() == 0) begin
            $display("pulse_channel_timer_duty_sweep regression: pass");
        end else begin
            $display("pulse_channel_timer_duty_sweep regression: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/pcts_pkg.sv
rtl/pcts_if.sv
rtl/pulse_channel_timer_duty_sweep.sv
bench/tb_pulse_channel_timer_duty_sweep.sv
